// ----- rtl/spi_cds_pkg.sv -----
// Shared constants and types for the SPI clock divider search block.
// No dependencies; imported by spi_cds_div and spi_clock_divider_search.
`timescale 1ns / 1ps

package spi_cds_pkg;

   localparam int DEFAULT_CLOCK_MHZ = 80;
   localparam int HZ_PER_MHZ        = 1000000;
   // width of the divider datapath at the default clock (80 MHz fits 27 bits)
   localparam int DEFAULT_DIV_W     = 27;

   localparam int N_MAX   = (1 << 6) - 1;
   localparam int PRE_MAX = (1 << 13) - 1;

   localparam logic [31:0] BYPASS_WORD = 32'h8000_0000;
   localparam logic [31:0] MIN_WORD    = 32'h7FFF_F020;

   // divider status back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- rtl/spi_clock_divider_search.sv -----
// SPI clock divider search: requested Hz in, 32-bit divider word plus bypass flag out.
// Bypass and below-minimum requests are answered directly from idle; a full search walks
//   n = 1..63 through the single shared divider and ends early on an exact match.
// Throughput: one item at a time; busy stays high until the result strobe is issued.
// Reset (synchronous, active high) returns to idle and drops the strobe; the receiver
//   cannot stall, the result is on rsp_* for exactly the one cycle rsp_valid is high.
// Depends on spi_cds_pkg and spi_cds_div.
`timescale 1ns / 1ps

module spi_clock_divider_search #(
   parameter int CLOCK_MHZ = spi_cds_pkg::DEFAULT_CLOCK_MHZ
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_requested_hz,
   output logic        rsp_valid,
   output logic [31:0] rsp_divider_word,
   output logic        rsp_sysclk_bypass
);
   import spi_cds_pkg::*;

   // system clock in Hz and the width that holds it; every search value fits that width
   localparam longint CLK_HZ = longint'(CLOCK_MHZ) * HZ_PER_MHZ;
   localparam int     CLK_W  = $clog2(CLK_HZ + 1);
   // lowest reachable rate: prescaler 8192 times divider 64
   localparam longint MIN_HZ = CLK_HZ / ((PRE_MAX + 1) * (N_MAX + 1));
   localparam int     P_W    = CLK_W + 2;

   // candidate index: 0, 1, 2 stand for prescaler q-2, q-1, q
   localparam logic [1:0] IDX_FIRST = 2'd0;
   localparam logic [1:0] IDX_LAST  = 2'd2;

   typedef enum logic [6:0] {
      ST_IDLE     = 7'b000_0001,
      ST_A_GO     = 7'b000_0010,  // launch clk / (n+1)
      ST_A_WAIT   = 7'b000_0100,  // then launch a / freq
      ST_Q_WAIT   = 7'b000_1000,  // capture q
      ST_P_GO     = 7'b001_0000,  // clamp prescaler, launch a / (pre+1)
      ST_ACT_WAIT = 7'b010_0000,  // judge achieved rate
      ST_DONE     = 7'b100_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [CLK_W-1:0]  freq_ff, freq_in;
   logic [5:0]        n_ff, n_in;
   logic [1:0]        idx_ff, idx_in;
   logic [CLK_W-1:0]  a_ff, a_in;
   logic [CLK_W-1:0]  q_ff, q_in;
   logic [12:0]       pre_ff, pre_in;
   logic [CLK_W-1:0]  best_freq_ff, best_freq_in;
   logic [31:0]       best_word_ff, best_word_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_word_ff, rsp_word_in;
   logic              rsp_bypass_ff, rsp_bypass_in;

   logic              accept;
   logic              div_start;
   logic [CLK_W-1:0]  div_dividend;
   logic [CLK_W-1:0]  div_divisor;
   logic [CLK_W-1:0]  div_q;
   div_stat_type      div_stat;

   logic signed [P_W-1:0] p_s;
   logic [12:0]           pre_clamp;
   logic [5:0]            low_time;
   logic [31:0]           cand_word;

   assign accept = start && !busy;

   // p = q - 2 + idx, clamped to 0..8191
   assign p_s = signed'({2'b00, q_ff} + {{CLK_W{1'b0}}, idx_ff} - P_W'(2));

   always_comb begin
      if (p_s <= signed'(P_W'(0))) begin
         pre_clamp = '0;
      end else if (p_s > signed'(P_W'(PRE_MAX))) begin
         pre_clamp = 13'(PRE_MAX);
      end else begin
         pre_clamp = p_s[12:0];
      end
   end

   assign low_time  = 6'((7'(n_ff) + 7'd1) >> 1);
   // equal flag 0, high time 0
   assign cand_word = {1'b0, pre_ff, n_ff, 6'd0, low_time};

   spi_cds_div #(
      .DATA_W(CLK_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .dividend(div_dividend),
      .divisor (div_divisor),
      .quotient(div_q),
      .stat    (div_stat)
   );

   always_comb begin
      state_in      = state_ff;
      freq_in       = freq_ff;
      n_in          = n_ff;
      idx_in        = idx_ff;
      a_in          = a_ff;
      q_in          = q_ff;
      pre_in        = pre_ff;
      best_freq_in  = best_freq_ff;
      best_word_in  = best_word_ff;
      rsp_valid_in  = 1'b0;
      rsp_word_in   = rsp_word_ff;
      rsp_bypass_in = rsp_bypass_ff;
      div_start     = 1'b0;
      div_dividend  = a_ff;
      div_divisor   = freq_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_requested_hz >= 32'(CLK_HZ)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_word_in   = BYPASS_WORD;
                  rsp_bypass_in = 1'b1;
               end else if (req_requested_hz < 32'(MIN_HZ)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_word_in   = MIN_WORD;
                  rsp_bypass_in = 1'b0;
               end else begin
                  // below clk here, so the request fits CLK_W bits
                  freq_in      = req_requested_hz[CLK_W-1:0];
                  n_in         = 6'd1;
                  best_freq_in = '0;
                  best_word_in = '0;
                  state_in     = ST_A_GO;
               end
            end
         end
         ST_A_GO: begin
            div_start    = 1'b1;
            div_dividend = CLK_W'(CLK_HZ);
            div_divisor  = CLK_W'(n_ff) + CLK_W'(1);
            state_in     = ST_A_WAIT;
         end
         ST_A_WAIT: begin
            if (div_stat.done) begin
               a_in         = div_q;
               div_start    = 1'b1;
               div_dividend = div_q;
               div_divisor  = freq_ff;
               state_in     = ST_Q_WAIT;
            end
         end
         ST_Q_WAIT: begin
            if (div_stat.done) begin
               q_in     = div_q;
               idx_in   = IDX_FIRST;
               state_in = ST_P_GO;
            end
         end
         ST_P_GO: begin
            // floor(floor(clk/(n+1))/(pre+1)) equals clk/((pre+1)(n+1))
            pre_in       = pre_clamp;
            div_start    = 1'b1;
            div_dividend = a_ff;
            div_divisor  = CLK_W'(pre_clamp) + CLK_W'(1);
            state_in     = ST_ACT_WAIT;
         end
         ST_ACT_WAIT: begin
            if (div_stat.done) begin
               if (div_q == freq_ff) begin
                  best_word_in = cand_word;
                  state_in     = ST_DONE;
               end else begin
                  // under the request and closer than the best so far
                  if (div_q < freq_ff && div_q > best_freq_ff) begin
                     best_freq_in = div_q;
                     best_word_in = cand_word;
                  end
                  if (idx_ff != IDX_LAST) begin
                     idx_in   = idx_ff + 2'd1;
                     state_in = ST_P_GO;
                  end else if (n_ff == 6'(N_MAX)) begin
                     state_in = ST_DONE;
                  end else begin
                     n_in     = n_ff + 6'd1;
                     state_in = ST_A_GO;
                  end
               end
            end
         end
         ST_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_word_in   = best_word_ff;
            rsp_bypass_in = (best_word_ff == BYPASS_WORD);
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      freq_ff       <= freq_in;
      n_ff          <= n_in;
      idx_ff        <= idx_in;
      a_ff          <= a_in;
      q_ff          <= q_in;
      pre_ff        <= pre_in;
      best_freq_ff  <= best_freq_in;
      best_word_ff  <= best_word_in;
      rsp_word_ff   <= rsp_word_in;
      rsp_bypass_ff <= rsp_bypass_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_divider_word  = rsp_word_ff;
   assign rsp_sysclk_bypass = rsp_bypass_ff;

   // a result follows either a fast-path accept or the end of a search
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == ST_DONE) || $past(accept))
      else $error("result strobe without a source");

   // bypass flag only ever marks the bypass word
   a_bypass_word: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_bypass_ff |-> rsp_word_ff == BYPASS_WORD)
      else $error("bypass flag with a divided word");

   // while waiting on a divide, the divider is running or just finished
   a_wait_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_A_WAIT || state_ff == ST_Q_WAIT || state_ff == ST_ACT_WAIT)
         |-> div_stat.busy || div_stat.done)
      else $error("sequencer waiting on an idle divider");

   // best rate found never reaches the request
   a_best_below: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_P_GO |-> best_freq_ff < freq_ff)
      else $error("best rate at or above the request");

endmodule

// ----- rtl/spi_cds_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, DATA_W quotient bits per divide.
// Depends on spi_cds_pkg (status struct, default width).
`timescale 1ns / 1ps

module spi_cds_div #(
   parameter int DATA_W = spi_cds_pkg::DEFAULT_DIV_W
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DATA_W-1:0]         dividend,
   input  logic [DATA_W-1:0]         divisor,
   output logic [DATA_W-1:0]         quotient,
   output spi_cds_pkg::div_stat_type stat
);
   import spi_cds_pkg::*;

   localparam int CNT_W = $clog2(DATA_W + 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DATA_W-1:0] rem_ff, rem_in;
   logic [DATA_W-1:0] quo_ff, quo_in;
   logic [DATA_W-1:0] den_ff, den_in;

   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   diff;

   assign rem_sh = {rem_ff, quo_ff[DATA_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CNT_W'(DATA_W);
         rem_in = '0;
         quo_in = dividend;
         den_in = divisor;
      end else if (run_ff) begin
         // top bit clear: shifted remainder reached the divisor
         if (!diff[DATA_W]) begin
            rem_in = diff[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DATA_W-1:0];
            quo_in = {quo_ff[DATA_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient  = quo_ff;
   assign stat.busy = run_ff;
   assign stat.done = done_ff;

   // a new divide is never launched on top of a running one
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      start |-> !run_ff)
      else $error("divider restarted while running");

   // done pulses exactly once, right after the last step
   a_done_end: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff && $past(run_ff))
      else $error("divider done without a finishing run");

   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("divider done held longer than one cycle");

endmodule
